@@ sv/gsf_pkg.sv @@
// Shared types and constants of the Gaussian smoothing FIR.
`default_nettype none

package gsf_pkg;

  // Sample and weight formats.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int FRAC_SHIFT = 16;

  // Number of weight registers: the center tap and distances one to five.
  localparam int NCOEF     = 6;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OFF5   = 3'd5;

  // Reset weights, index 0 is the center tap.
  localparam logic [COEF_W-1:0] COEF_RESET [NCOEF] = '{
    16'd19026, 16'd14596, 16'd6608, 16'd1760, 16'd276, 16'd25
  };

  // A job holds up to fifteen results, enough for twenty-nine taps.
  localparam int CNT_W = 4;

  // Control part of one job passed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0] count;      // number of results the job gives
    logic             final_job;  // job closes a record
  } job_ctl_t;

endpackage

`default_nettype wire

@@ sv/gaussian_smoothing_fir.sv @@
// Top level of the Gaussian smoothing FIR: weight registers, front, queue and back.
// Throughput: one word per cycle; a word that closes a record queues up to TAPS/2+1
// results, which leave at one per cycle through the single multiply-accumulate pipe
// while out_ready allows. The input stalls while the two-entry job queue is full.
// Reset (rst, synchronous) clears the delay line, the record position and the
// pipeline, and loads the default Gaussian weights.
`default_nettype none

module gaussian_smoothing_fir #(
  parameter int TAPS = 11
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  signed [gsf_pkg::SAMPLE_W-1:0]   sample,
  input  wire                                   record_end,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [gsf_pkg::SAMPLE_W-1:0]   smoothed,
  output logic                                  final_out,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [gsf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [gsf_pkg::COEF_W-1:0]            cfg_data
);

  localparam int HALF  = TAPS / 2;
  localparam int WIN   = 2 * HALF + 1;
  localparam int JOB_W = WIN * gsf_pkg::SAMPLE_W + $bits(gsf_pkg::job_ctl_t);

  logic [gsf_pkg::NCOEF-1:0][gsf_pkg::COEF_W-1:0] coef;
  logic                                          q_push;
  logic                                          q_full;
  logic                                          q_pop;
  logic                                          q_valid;
  logic [WIN-1:0][gsf_pkg::SAMPLE_W-1:0]         f_win;
  gsf_pkg::job_ctl_t                             f_ctl;
  logic [WIN-1:0][gsf_pkg::SAMPLE_W-1:0]         b_win;
  gsf_pkg::job_ctl_t                             b_ctl;

  // Weight registers; writes beyond the last register are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gsf_pkg::NCOEF; i++) begin
        coef[i] <= gsf_pkg::COEF_RESET[i];
      end
    end else if (cfg_valid && cfg_index >= gsf_pkg::CFG_COEF_CENTER
                 && cfg_index <= gsf_pkg::CFG_COEF_OFF5) begin
      for (int i = 0; i < gsf_pkg::NCOEF; i++) begin
        if (cfg_index == gsf_pkg::CFG_IDX_W'(i)) begin
          coef[i] <= cfg_data;
        end
      end
    end
  end

  gsf_front #(
    .HALF (HALF)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .record_end (record_end),
    .q_full     (q_full),
    .q_push     (q_push),
    .job_win    (f_win),
    .job_ctl    (f_ctl)
  );

  gsf_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    ({f_win, f_ctl}),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rdata    ({b_win, b_ctl})
  );

  gsf_back #(
    .HALF (HALF)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_win     (b_win),
    .q_ctl     (b_ctl),
    .q_pop     (q_pop),
    .coef      (coef),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .smoothed  (smoothed),
    .final_out (final_out)
  );

endmodule

`default_nettype wire

@@ sv/gsf_front.sv @@
// Front end: accepts samples, keeps the delay line and issues filter jobs.
`default_nettype none

module gsf_front #(
  parameter int HALF = 5
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire  signed [gsf_pkg::SAMPLE_W-1:0]      sample,
  input  wire                                      record_end,
  input  wire                                      q_full,
  output logic                                     q_push,
  output logic [2*HALF:0][gsf_pkg::SAMPLE_W-1:0]   job_win,
  output gsf_pkg::job_ctl_t                        job_ctl
);

  localparam int WIN      = 2 * HALF + 1;
  localparam int DL_DEPTH = 2 * HALF;
  localparam int SEEN_W   = $clog2(HALF + 1);

  logic signed [gsf_pkg::SAMPLE_W-1:0] dline [DL_DEPTH];
  logic signed [gsf_pkg::SAMPLE_W-1:0] win_raw [WIN];
  logic [SEEN_W-1:0]                   seen_count;
  logic [SEEN_W-1:0]                   shift_amt;
  logic                                accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // The current window: the new word followed by the delay line.
  always_comb begin
    win_raw[0] = sample;
    for (int j = 1; j < WIN; j++) begin
      win_raw[j] = dline[j-1];
    end
  end

  // A closing word starts its first result nearer the record end, so the
  // window is moved up and zeros stand in for words past the end.
  assign shift_amt = record_end ? (SEEN_W'(HALF) - seen_count) : '0;

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      job_win[k] = '0;
      for (int sh = 0; sh <= HALF; sh++) begin
        if (shift_amt == SEEN_W'(sh) && k >= sh) begin
          job_win[k] = win_raw[k-sh];
        end
      end
    end
  end

  // Classify the word: a closing word flushes all pending results, a full
  // window gives one result, and an early word of a record gives none.
  always_comb begin
    job_ctl.final_job = record_end;
    job_ctl.count     = record_end ? (gsf_pkg::CNT_W'(seen_count) + gsf_pkg::CNT_W'(1))
                                   : gsf_pkg::CNT_W'(1);
    q_push            = accept && (record_end || seen_count == SEEN_W'(HALF));
  end

  // Delay line and record position.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
      for (int j = 0; j < DL_DEPTH; j++) begin
        dline[j] <= '0;
      end
    end else if (accept) begin
      if (record_end) begin
        seen_count <= '0;
        for (int j = 0; j < DL_DEPTH; j++) begin
          dline[j] <= '0;
        end
      end else begin
        for (int j = 0; j < DL_DEPTH; j++) begin
          dline[j] <= win_raw[j];
        end
        if (seen_count != SEEN_W'(HALF)) begin
          seen_count <= seen_count + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/gsf_queue.sv @@
// Two-entry job queue between the front end and the filter back end.
`default_nettype none

module gsf_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire  [W-1:0] wdata,
  output logic         full,
  input  wire          pop,
  output logic         rd_valid,
  output logic [W-1:0] rdata
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rdata    = entry[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/gsf_back.sv @@
// Back end: runs each job through the symmetric multiply-accumulate pipeline.
`default_nettype none

module gsf_back #(
  parameter int HALF = 5
) (
  input  wire                                                 clk,
  input  wire                                                 rst,
  input  wire                                                 q_valid,
  input  wire  [2*HALF:0][gsf_pkg::SAMPLE_W-1:0]              q_win,
  input  gsf_pkg::job_ctl_t                                   q_ctl,
  output logic                                                q_pop,
  input  wire  [gsf_pkg::NCOEF-1:0][gsf_pkg::COEF_W-1:0]      coef,
  output logic                                                out_valid,
  input  wire                                                 out_ready,
  output logic signed [gsf_pkg::SAMPLE_W-1:0]                 smoothed,
  output logic                                                final_out
);

  localparam int WIN    = 2 * HALF + 1;
  localparam int NMUL   = (HALF < gsf_pkg::NCOEF - 1) ? HALF + 1 : gsf_pkg::NCOEF;
  localparam int NA     = (NMUL + 1) / 2;
  localparam int PRE_W  = gsf_pkg::SAMPLE_W + 1;
  localparam int PROD_W = 2 * PRE_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) <<< (gsf_pkg::FRAC_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);

  // Job being issued.
  logic [WIN-1:0][gsf_pkg::SAMPLE_W-1:0] cur_win;
  logic [gsf_pkg::CNT_W-1:0]             cur_left;
  logic                                  cur_final;
  logic                                  cur_valid;

  // Pipeline stages.
  logic signed [PRE_W-1:0]  pa   [NMUL];
  logic signed [PROD_W-1:0] prod [NMUL];
  logic signed [ACC_W-1:0]  sum_a;
  logic signed [ACC_W-1:0]  sum_b;
  logic a_valid, b_valid, c_valid;
  logic a_final, b_final, c_final;

  logic                    advance;
  logic                    issue;
  logic                    cur_last;
  logic signed [PRE_W-1:0]  pa_next [NMUL];
  logic signed [PROD_W-1:0] prod_next [NMUL];
  logic signed [PRE_W-1:0]  cf [NMUL];
  logic signed [ACC_W-1:0]  sum_a_next;
  logic signed [ACC_W-1:0]  sum_b_next;
  logic signed [ACC_W-1:0]  total;
  logic signed [ACC_W-1:0]  total_q;
  logic signed [gsf_pkg::SAMPLE_W-1:0] sat_q;

  // The whole pipeline moves when the output word is free or being taken.
  assign advance  = !out_valid || out_ready;
  assign issue    = advance && cur_valid;
  assign cur_last = (cur_left == gsf_pkg::CNT_W'(1));
  assign q_pop    = advance && q_valid && (!cur_valid || cur_last);

  // Fold the symmetric taps together before the multipliers.
  always_comb begin
    pa_next[0] = $signed({cur_win[HALF][gsf_pkg::SAMPLE_W-1], cur_win[HALF]});
    for (int d = 1; d < NMUL; d++) begin
      pa_next[d] = $signed({cur_win[HALF+d][gsf_pkg::SAMPLE_W-1], cur_win[HALF+d]})
                 + $signed({cur_win[HALF-d][gsf_pkg::SAMPLE_W-1], cur_win[HALF-d]});
    end
  end

  // One multiplier for each distance from the center that has a weight.
  always_comb begin
    for (int d = 0; d < NMUL; d++) begin
      cf[d]        = $signed({1'b0, coef[d]});
      prod_next[d] = pa[d] * cf[d];
    end
  end

  // Two partial sums, the rounding bias rides in the first.
  always_comb begin
    sum_a_next = RND;
    sum_b_next = '0;
    for (int i = 0; i < NMUL; i++) begin
      if (i < NA) begin
        sum_a_next = sum_a_next + ACC_W'(prod[i]);
      end else begin
        sum_b_next = sum_b_next + ACC_W'(prod[i]);
      end
    end
  end

  // Final sum, scale to Q1.15 rounding to nearest (ties upward), then saturate.
  always_comb begin
    total   = sum_a + sum_b;
    total_q = total >>> gsf_pkg::FRAC_SHIFT;
    if (total_q > Q_MAX) begin
      sat_q = 16'sh7fff;
    end else if (total_q < Q_MIN) begin
      sat_q = -16'sh8000;
    end else begin
      sat_q = total_q[gsf_pkg::SAMPLE_W-1:0];
    end
  end

  // Valid bits of the job register and the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (issue && cur_last) begin
        cur_valid <= 1'b0;
      end
      a_valid   <= cur_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // Job register and data path: a job issues one result per cycle while the
  // pipe moves, shifting its window up a word per result toward the record end.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (q_pop) begin
        cur_win   <= q_win;
        cur_left  <= q_ctl.count;
        cur_final <= q_ctl.final_job;
      end else if (issue) begin
        cur_win[0] <= '0;
        for (int k = 1; k < WIN; k++) begin
          cur_win[k] <= cur_win[k-1];
        end
        cur_left <= cur_left - gsf_pkg::CNT_W'(1);
      end
      for (int d = 0; d < NMUL; d++) begin
        pa[d]   <= pa_next[d];
        prod[d] <= prod_next[d];
      end
      a_final   <= cur_final && cur_last;
      b_final   <= a_final;
      sum_a     <= sum_a_next;
      sum_b     <= sum_b_next;
      c_final   <= b_final;
      smoothed  <= sat_q;
      final_out <= c_final;
    end
  end

endmodule

`default_nettype wire

@@ sv/gsf_checker.sv @@
// Port-level checks of the Gaussian smoothing FIR and their binding.
`default_nettype none

module gsf_checker (
  input wire                                  clk,
  input wire                                  rst,
  input wire                                  in_ready,
  input wire                                  out_valid,
  input wire                                  out_ready,
  input wire signed [gsf_pkg::SAMPLE_W-1:0]   smoothed,
  input wire                                  final_out,
  input wire                                  cfg_ready
);

  // A result word that is not taken stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed) && $stable(final_out))
    else $error("result word changed while stalled");

  // Reset empties the pipeline and the job queue.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // Weight writes are never refused.
  assert property (@(posedge clk) disable iff (rst) in_ready || !in_ready |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind gaussian_smoothing_fir gsf_checker u_gsf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .smoothed  (smoothed),
  .final_out (final_out),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
